[hdl/ufst_pkg.sv]
package ufst_pkg;

    localparam int ID_W    = 32;
    localparam int WORD_W  = 64;
    localparam int FRAME_W = 3 * WORD_W;
    localparam int STAT_W  = 3;
    localparam int OCC_W   = 5;

    // low status bits that must be clear in a saved frame
    localparam logic [WORD_W-1:0] STATUS_LOW_MASK = 64'hF;

    typedef enum logic [1:0] {
        CMD_ADMIT,
        CMD_CAPTURE,
        CMD_RESTORE,
        CMD_RETIRE
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_RESERVED,
        ST_BAD_FRAME,
        ST_DUPLICATE,
        ST_UNKNOWN,
        ST_FULL
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic done;
        logic found;
        logic free_found;
    } t_srch_flags;

    function automatic logic frame_ok(
        input logic [WORD_W-1:0] st,
        input logic [WORD_W-1:0] addr,
        input logic [WORD_W-1:0] sp
    );
        return ((st & STATUS_LOW_MASK) == '0) && (addr != '0) && (sp != '0);
    endfunction

endpackage

[hdl/ufst_ram.sv]
module ufst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/ufst_search.sv]
module ufst_search
    import ufst_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int IW         = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ID_W-1:0]       i_id,
    input  logic [SLOT_COUNT-1:0] i_used,
    input  logic [ID_W-1:0]       i_rdata,
    output logic [IW-1:0]         o_raddr,
    output t_srch_flags           o_flags,
    output logic [IW-1:0]         o_hit_idx,
    output logic [IW-1:0]         o_free_idx
);

    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    logic            r_rd_act;
    logic            r_cmp_act;
    logic            r_done;
    logic            r_found;
    logic            r_free_found;
    logic [IW-1:0]   r_rd_idx;
    logic [IW-1:0]   r_cmp_idx;
    logic [IW-1:0]   r_hit;
    logic [IW-1:0]   r_free;
    logic [ID_W-1:0] r_id;
    logic            hit_now;
    logic            free_now;

    // compare stage sees the thread id read in the cycle before
    assign hit_now  = r_cmp_act && i_used[r_cmp_idx] && (i_rdata == r_id);
    assign free_now = r_cmp_act && !i_used[r_cmp_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_act     <= 1'b0;
            r_cmp_act    <= 1'b0;
            r_done       <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_done    <= r_cmp_act && (r_cmp_idx == LAST);
            r_cmp_act <= r_rd_act;
            if (i_start) begin
                r_rd_act     <= 1'b1;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (r_rd_act && (r_rd_idx == LAST)) begin
                    r_rd_act <= 1'b0;
                end
                if (hit_now) begin
                    r_found <= 1'b1;
                end
                if (free_now) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
        if (i_start) begin
            r_id     <= i_id;
            r_rd_idx <= '0;
        end else if (r_rd_act) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        // keep the lowest matching and lowest free slot
        if (hit_now && !r_found) begin
            r_hit <= r_cmp_idx;
        end
        if (free_now && !r_free_found) begin
            r_free <= r_cmp_idx;
        end
    end

    assign o_raddr            = r_rd_idx;
    assign o_flags.done       = r_done;
    assign o_flags.found      = r_found;
    assign o_flags.free_found = r_free_found;
    assign o_hit_idx          = r_hit;
    assign o_free_idx         = r_free;

endmodule

[hdl/user_frame_slot_table_unit.sv]
// an accepted item passes through the scan, fetch and exec states before o_out_valid
// rises from the result register; items are taken one at a time, and the scan of the
// thread id ram reads one slot per cycle, followed by a frame ram read and a write-back
// the result register lets the next item in while a result waits
// reset: synchronous active low, clears the occupied bits, the count and the
// reserved id register; ram contents are masked by the occupied bits until written
module user_frame_slot_table_unit
    import ufst_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ID_W-1:0]   i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [ID_W-1:0]   i_thread_id,
    input  logic [WORD_W-1:0] i_saved_status,
    input  logic [WORD_W-1:0] i_return_address,
    input  logic [WORD_W-1:0] i_user_stack,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic              o_found,
    output logic [WORD_W-1:0] o_status_out,
    output logic [WORD_W-1:0] o_address_out,
    output logic [WORD_W-1:0] o_stack_out,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    t_state            r_state, n_state;
    logic [ID_W-1:0]   r_resv;
    t_cmd              r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [WORD_W-1:0] r_st, r_addr, r_sp;
    logic [SLOT_COUNT-1:0] r_used, n_used;
    logic [CW-1:0]     r_count, n_count;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_found;
    logic [WORD_W-1:0] r_out_st, r_out_addr, r_out_sp;
    logic [OCC_W-1:0]  r_out_occ;

    logic              start;
    logic              can_load;
    logic              exec_go;
    t_status           res_status;
    logic              res_ok;
    logic              thr_we, frm_we;
    logic              set_used, clr_used;
    logic [IW-1:0]     waddr;

    logic [IW-1:0]     thr_raddr;
    logic [ID_W-1:0]   thr_rdata;
    logic [FRAME_W-1:0] frm_rdata;
    logic [WORD_W-1:0] rd_st, rd_addr, rd_sp;

    t_srch_flags       flags;
    logic [IW-1:0]     hit_idx, free_idx;

    ufst_search #(
        .SLOT_COUNT (SLOT_COUNT),
        .IW         (IW)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_id       (i_thread_id),
        .i_used     (r_used),
        .i_rdata    (thr_rdata),
        .o_raddr    (thr_raddr),
        .o_flags    (flags),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx)
    );

    ufst_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOT_COUNT)
    ) u_thread_ram (
        .i_clk   (i_clk),
        .i_we    (thr_we),
        .i_waddr (waddr),
        .i_wdata (r_id),
        .i_raddr (thr_raddr),
        .o_rdata (thr_rdata)
    );

    ufst_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (SLOT_COUNT)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_waddr (waddr),
        .i_wdata ({r_st, r_addr, r_sp}),
        .i_raddr (hit_idx),
        .o_rdata (frm_rdata)
    );

    assign rd_st   = frm_rdata[FRAME_W-1 -: WORD_W];
    assign rd_addr = frm_rdata[2*WORD_W-1 -: WORD_W];
    assign rd_sp   = frm_rdata[WORD_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SCAN;
            S_SCAN:  if (flags.done) n_state = S_FETCH;
            S_FETCH: n_state = S_EXEC;
            S_EXEC:  if (can_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and command decisions
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        start      = o_in_ready && i_in_valid;
        can_load   = !r_out_valid || i_out_ready;
        exec_go    = (r_state == S_EXEC) && can_load;
        res_status = ST_OK;
        res_ok     = 1'b0;
        thr_we     = 1'b0;
        frm_we     = 1'b0;
        set_used   = 1'b0;
        clr_used   = 1'b0;
        waddr      = hit_idx;
        unique case (r_cmd)
            CMD_ADMIT: begin
                waddr = free_idx;
                if (r_id == r_resv) begin
                    res_status = ST_RESERVED;
                end else if (!frame_ok(r_st, r_addr, r_sp)) begin
                    res_status = ST_BAD_FRAME;
                end else if (flags.found) begin
                    res_status = ST_DUPLICATE;
                end else if (!flags.free_found) begin
                    res_status = ST_FULL;
                end else begin
                    thr_we   = 1'b1;
                    frm_we   = 1'b1;
                    set_used = 1'b1;
                end
            end
            CMD_CAPTURE: begin
                if (!frame_ok(r_st, r_addr, r_sp)) begin
                    res_status = ST_BAD_FRAME;
                end else if (!flags.found) begin
                    res_status = ST_UNKNOWN;
                end else begin
                    frm_we = 1'b1;
                end
            end
            CMD_RESTORE: begin
                if (!flags.found) begin
                    res_status = ST_UNKNOWN;
                end else if (!frame_ok(rd_st, rd_addr, rd_sp)) begin
                    res_status = ST_BAD_FRAME;
                end else begin
                    res_ok = 1'b1;
                end
            end
            CMD_RETIRE: begin
                if (!flags.found) begin
                    res_status = ST_UNKNOWN;
                end else begin
                    clr_used = 1'b1;
                end
            end
            default: res_status = ST_OK;
        endcase
        thr_we   = thr_we && exec_go;
        frm_we   = frm_we && exec_go;
        set_used = set_used && exec_go;
        clr_used = clr_used && exec_go;
    end

    always_comb begin
        n_used  = r_used;
        n_count = r_count;
        if (set_used) begin
            n_used[waddr] = 1'b1;
            n_count       = r_count + 1'b1;
        end else if (clr_used) begin
            n_used[waddr] = 1'b0;
            n_count       = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_resv      <= '0;
            r_used      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_resv <= i_cfg_wdata;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_id   <= i_thread_id;
            r_st   <= i_saved_status;
            r_addr <= i_return_address;
            r_sp   <= i_user_stack;
        end
        if (exec_go) begin
            r_out_status <= res_status;
            r_out_found  <= flags.found;
            r_out_st     <= res_ok ? rd_st   : '0;
            r_out_addr   <= res_ok ? rd_addr : '0;
            r_out_sp     <= res_ok ? rd_sp   : '0;
            r_out_occ    <= OCC_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_status_out  = r_out_st;
    assign o_address_out = r_out_addr;
    assign o_stack_out   = r_out_sp;
    assign o_occupancy   = r_out_occ;

endmodule

[hdl/ufst_check.sv]
module ufst_check
    import ufst_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] o_status,
    input logic              o_found,
    input logic [WORD_W-1:0] o_status_out,
    input logic [WORD_W-1:0] o_address_out,
    input logic [WORD_W-1:0] o_stack_out
);

    // one item at a time: no second accept right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_found) && $stable(o_status_out)))
        else $error("stalled item changed");

    // frame fields only carry data on a good result
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
            (o_status_out == '0 && o_address_out == '0 && o_stack_out == '0))
        else $error("frame data on a failed command");

    // duplicate means found, unknown means not found
    a_found_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status != ST_DUPLICATE || o_found)
            && (o_status != ST_UNKNOWN || !o_found)))
        else $error("found flag disagrees with status");

    // a good status word restored never has low bits set
    a_restore_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status_out != '0) |->
            ((o_status_out & STATUS_LOW_MASK) == '0 && o_address_out != '0
                && o_stack_out != '0))
        else $error("restored frame is malformed");

endmodule

bind user_frame_slot_table_unit ufst_check u_check (.*);

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufst_pkg::*;

    localparam int SLOTS       = 16;
    localparam int PCT_IDLE    = 26;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = SLOTS + 8;
    localparam int ID_POOL     = 24;
    localparam int PHASE_ITEMS = 100;
    localparam int PHASES      = 5;

    typedef struct {
        t_status           status;
        logic              found;
        logic [WORD_W-1:0] st_out;
        logic [WORD_W-1:0] addr_out;
        logic [WORD_W-1:0] sp_out;
        logic [OCC_W-1:0]  occ;
    } t_frame_result;

    // dut connections
    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_we         = 1'b0;
    logic [ID_W-1:0]   cfg_wdata      = '0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic [1:0]        cmd            = CMD_ADMIT;
    logic [ID_W-1:0]   thread_id      = '0;
    logic [WORD_W-1:0] saved_status   = '0;
    logic [WORD_W-1:0] return_address = '0;
    logic [WORD_W-1:0] user_stack     = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [STAT_W-1:0] status;
    logic              found;
    logic [WORD_W-1:0] status_out;
    logic [WORD_W-1:0] address_out;
    logic [WORD_W-1:0] stack_out;
    logic [OCC_W-1:0]  occupancy;

    // predicted table contents
    bit              tbl_used   [SLOTS];
    bit [ID_W-1:0]   tbl_thread [SLOTS];
    bit [WORD_W-1:0] tbl_status [SLOTS];
    bit [WORD_W-1:0] tbl_addr   [SLOTS];
    bit [WORD_W-1:0] tbl_stack  [SLOTS];
    bit [OCC_W-1:0]  tbl_count;
    bit [ID_W-1:0]   rsv_id;

    t_frame_result   pending_results[$];
    bit [ID_W-1:0]   id_pool[ID_POOL];
    bit              steady_phase = 1'b0;

    int mismatches      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int config_writes   = 0;
    int peak_occ        = 0;
    int quiet_cycles    = 0;
    int status_tally[6];
    int cmd_tally[4];

    user_frame_slot_table_unit #(
        .SLOT_COUNT(SLOTS)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_cmd           (cmd),
        .i_thread_id     (thread_id),
        .i_saved_status  (saved_status),
        .i_return_address(return_address),
        .i_user_stack    (user_stack),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .o_found         (found),
        .o_status_out    (status_out),
        .o_address_out   (address_out),
        .o_stack_out     (stack_out),
        .o_occupancy     (occupancy)
    );

    always #1 clk = ~clk;

    function automatic bit frame_valid(input bit [WORD_W-1:0] st, input bit [WORD_W-1:0] addr,
                                       input bit [WORD_W-1:0] sp);
        return ((st & STATUS_LOW_MASK) == '0) && (addr != '0) && (sp != '0);
    endfunction

    // applies one command to the predicted table and returns its result
    function automatic t_frame_result predict_table_result(input t_cmd op,
            input bit [ID_W-1:0] id, input bit [WORD_W-1:0] st,
            input bit [WORD_W-1:0] addr, input bit [WORD_W-1:0] sp);
        t_frame_result r;
        int hit;
        int slot;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && tbl_used[i] && tbl_thread[i] == id) hit = i;
            if (slot < 0 && !tbl_used[i]) slot = i;
        end
        r.status   = ST_OK;
        r.found    = (hit >= 0);
        r.st_out   = '0;
        r.addr_out = '0;
        r.sp_out   = '0;
        case (op)
            CMD_ADMIT: begin
                if (id == rsv_id) r.status = ST_RESERVED;
                else if (!frame_valid(st, addr, sp)) r.status = ST_BAD_FRAME;
                else if (hit >= 0) r.status = ST_DUPLICATE;
                else if (slot < 0) r.status = ST_FULL;
                else begin
                    tbl_used[slot]   = 1'b1;
                    tbl_thread[slot] = id;
                    tbl_status[slot] = st;
                    tbl_addr[slot]   = addr;
                    tbl_stack[slot]  = sp;
                    tbl_count++;
                end
            end
            CMD_CAPTURE: begin
                // frame is checked before the lookup
                if (!frame_valid(st, addr, sp)) r.status = ST_BAD_FRAME;
                else if (hit < 0) r.status = ST_UNKNOWN;
                else begin
                    tbl_status[hit] = st;
                    tbl_addr[hit]   = addr;
                    tbl_stack[hit]  = sp;
                end
            end
            CMD_RESTORE: begin
                if (hit < 0) r.status = ST_UNKNOWN;
                else if (!frame_valid(tbl_status[hit], tbl_addr[hit], tbl_stack[hit]))
                    r.status = ST_BAD_FRAME;
                else begin
                    r.st_out   = tbl_status[hit];
                    r.addr_out = tbl_addr[hit];
                    r.sp_out   = tbl_stack[hit];
                end
            end
            default: begin
                if (hit < 0) r.status = ST_UNKNOWN;
                else begin
                    tbl_used[hit]   = 1'b0;
                    tbl_thread[hit] = '0;
                    tbl_status[hit] = '0;
                    tbl_addr[hit]   = '0;
                    tbl_stack[hit]  = '0;
                    if (tbl_count != 0) tbl_count--;
                end
            end
        endcase
        r.occ = tbl_count;
        return r;
    endfunction

    function automatic bit [ID_W-1:0] pick_present_id();
        int live[$];
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i]) live.push_back(i);
        if (live.size() == 0) return $urandom;
        return tbl_thread[live[$urandom_range(live.size() - 1)]];
    endfunction

    function automatic void make_frame(input bit good, output logic [WORD_W-1:0] st,
                                       output logic [WORD_W-1:0] addr,
                                       output logic [WORD_W-1:0] sp);
        st   = {$urandom, $urandom} & ~STATUS_LOW_MASK;
        addr = {$urandom, $urandom};
        sp   = {$urandom, $urandom};
        if (addr == '0) addr = 64'h1;
        if (sp == '0) sp = 64'h8;
        if (!good) begin
            case ($urandom_range(2))
                0: st[3:0] = 4'($urandom_range(15, 1));
                1: addr = '0;
                default: sp = '0;
            endcase
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on %s at %0t ns: got %h, expected %h (result %0d)",
                     what, $time, got, want, results_checked);
    endtask

    // valid stays high from one item to the next unless a gap is taken
    task automatic send_item(input t_cmd op, input logic [ID_W-1:0] id,
                             input logic [WORD_W-1:0] st, input logic [WORD_W-1:0] addr,
                             input logic [WORD_W-1:0] sp);
        t_frame_result r;
        if (!steady_phase && $urandom_range(99) < PCT_IDLE) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3 * SLOTS + 8, 1)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= op;
        thread_id      <= id;
        saved_status   <= st;
        return_address <= addr;
        user_stack     <= sp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = predict_table_result(op, id, st, addr, sp);
        pending_results.push_back(r);
        items_sent++;
        cmd_tally[int'(op)]++;
        status_tally[int'(r.status)]++;
        if (int'(r.occ) > peak_occ) peak_occ = int'(r.occ);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reserved_id(input logic [ID_W-1:0] value);
        wait_for_results();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rsv_id = value;
        config_writes++;
    endtask

    task automatic send_random_item(input bit draining);
        t_cmd              op;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] st;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] sp;
        int                roll;
        roll = $urandom_range(99);
        if (roll < (draining ? 15 : 45)) op = CMD_ADMIT;
        else if (roll < (draining ? 35 : 65)) op = CMD_CAPTURE;
        else if (roll < (draining ? 55 : 85)) op = CMD_RESTORE;
        else op = CMD_RETIRE;
        roll = $urandom_range(99);
        if (roll < 45) id = pick_present_id();
        else if (roll < 80) id = id_pool[$urandom_range(ID_POOL - 1)];
        else if (roll < 86) id = rsv_id;
        else id = $urandom;
        make_frame($urandom_range(99) < 82, st, addr, sp);
        send_item(op, id, st, addr, sp);
    endtask

    task automatic test_admit_checks();
        // reserved id wins over a bad frame
        send_item(CMD_ADMIT, 32'h0, 64'h10, 64'h1, 64'h1);
        send_item(CMD_ADMIT, 32'h0, 64'h1, 64'h0, 64'h0);
        send_item(CMD_ADMIT, 32'h1, 64'h8, 64'h1, 64'h1);
        send_item(CMD_ADMIT, 32'h1, 64'h0, 64'h0, 64'h1);
        send_item(CMD_ADMIT, 32'h1, 64'h0, 64'h1, 64'h0);
        send_item(CMD_ADMIT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, '1, '1);
        send_item(CMD_ADMIT, 32'h1, 64'h0, 64'h1, 64'h1);
        send_item(CMD_ADMIT, 32'hFFFF_FFFF, 64'h0, 64'h1, 64'h1);
        // bad frame is reported ahead of duplicate
        send_item(CMD_ADMIT, 32'hFFFF_FFFF, 64'h7, 64'h1, 64'h1);
    endtask

    task automatic test_capture_restore();
        send_item(CMD_CAPTURE, 32'h8000_0000, 64'h2, 64'h1, 64'h1);
        send_item(CMD_CAPTURE, 32'h8000_0000, 64'h0, 64'h1, 64'h1);
        send_item(CMD_RESTORE, 32'hFFFF_FFFF, 64'h5, '0, '1);
        send_item(CMD_CAPTURE, 32'hFFFF_FFFF, 64'hA5A5_A5A5_A5A5_A5A0,
                  64'h5A5A_5A5A_5A5A_5A5A, 64'h8000_0000_0000_0000);
        send_item(CMD_RESTORE, 32'hFFFF_FFFF, '1, '1, '1);
        send_item(CMD_RESTORE, 32'h8000_0000, '0, '0, '0);
    endtask

    task automatic test_retire();
        send_item(CMD_RETIRE, 32'hFFFF_FFFF, '1, '0, '1);
        send_item(CMD_RETIRE, 32'hFFFF_FFFF, '0, '0, '0);
        send_item(CMD_RESTORE, 32'hFFFF_FFFF, '0, '0, '0);
        send_item(CMD_RETIRE, 32'h1, '0, '0, '0);
    endtask

    task automatic test_reserved_id();
        write_reserved_id(32'hFFFF_FFFF);
        send_item(CMD_ADMIT, 32'h0, 64'h100, 64'h200, 64'h300);
        send_item(CMD_ADMIT, 32'hFFFF_FFFF, 64'h0, 64'h1, 64'h1);
        // reserving an id that is already present: admit says reserved, not duplicate
        write_reserved_id(32'h0);
        send_item(CMD_ADMIT, 32'h0, 64'h0, 64'h1, 64'h1);
        send_item(CMD_CAPTURE, 32'h0, 64'hF0, 64'h2, 64'h3);
        send_item(CMD_RESTORE, 32'h0, '0, '0, '0);
        send_item(CMD_RETIRE, 32'h0, '0, '0, '0);
    endtask

    task automatic test_fill_drain();
        logic [WORD_W-1:0] st;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] sp;
        write_reserved_id($urandom);
        // three admits beyond the last slot hit the full table
        for (int n = 0; n < SLOTS + 3; n++) begin
            make_frame(1'b1, st, addr, sp);
            send_item(CMD_ADMIT, $urandom, st, addr, sp);
        end
        for (int n = 0; n < 6; n++) begin
            make_frame(n[0], st, addr, sp);
            send_item(n[1] ? CMD_CAPTURE : CMD_RESTORE,
                      pick_present_id(), st, addr, sp);
        end
        while (tbl_count != 0) begin
            make_frame(1'b0, st, addr, sp);
            send_item(CMD_RETIRE, pick_present_id(), st, addr, sp);
        end
    endtask

    task automatic test_random();
        bit draining;
        draining = 1'b0;
        for (int i = 0; i < ID_POOL; i++) id_pool[i] = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_reserved_id($urandom);
                1: write_reserved_id(32'hFFFF_FFFF);
                2: write_reserved_id(pick_present_id());
                3: write_reserved_id(32'h0);
                default: write_reserved_id(id_pool[$urandom_range(ID_POOL - 1)]);
            endcase
            steady_phase <= (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (tbl_count == SLOTS && $urandom_range(3) == 0) draining = 1'b1;
                else if (tbl_count <= 1) draining = 1'b0;
                send_random_item(draining);
            end
        end
        steady_phase <= 1'b0;
    endtask

    always @(posedge clk) begin
        out_ready <= steady_phase || ($urandom_range(99) >= PCT_IDLE);
    end

    always @(posedge clk) begin : result_check
        t_frame_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", WORD_W'(status), '0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (status !== want.status)
                    report_mismatch("status", WORD_W'(status), WORD_W'(want.status));
                if (found !== want.found)
                    report_mismatch("found", WORD_W'(found), WORD_W'(want.found));
                if (status_out !== want.st_out)
                    report_mismatch("status_out", status_out, want.st_out);
                if (address_out !== want.addr_out)
                    report_mismatch("address_out", address_out, want.addr_out);
                if (stack_out !== want.sp_out)
                    report_mismatch("stack_out", stack_out, want.sp_out);
                if (occupancy !== want.occ)
                    report_mismatch("occupancy", WORD_W'(occupancy), WORD_W'(want.occ));
            end
        end
    end

    // ends the run if neither side moves an item for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL user_frame_slot_table_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_admit_checks();
        test_capture_restore();
        test_retire();
        test_reserved_id();
        test_fill_drain();
        test_random();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $write("ran %0d items (admit %0d, capture %0d, restore %0d, retire %0d), ",
               items_sent, cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3]);
        $display("%0d reserved id writes, peak occupancy %0d", config_writes, peak_occ);
        $write("outcomes: ok %0d, reserved %0d, bad frame %0d, duplicate %0d, ",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        $display("unknown %0d, full %0d; %0d results checked, %0d mismatches",
                 status_tally[4], status_tally[5], results_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS user_frame_slot_table_unit");
        end else begin
            $display("FAIL user_frame_slot_table_unit");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/ufst_pkg.sv
hdl/ufst_ram.sv
hdl/ufst_search.sv
hdl/user_frame_slot_table_unit.sv
hdl/ufst_check.sv
tb/tb.sv
